@@ hdl/thv_pkg.sv @@
// Shared constants, codes and helper functions of the track header validator.
package thv_pkg;

    // Header geometry
    localparam int HEADER_BYTES = 40;
    localparam int AXES         = 6;

    localparam int POS_W = 8;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_BYTES - 1);

    // Byte positions inside the header
    localparam logic [POS_W-1:0] POS_VERSION_LO = POS_W'(4);
    localparam logic [POS_W-1:0] POS_VERSION_HI = POS_W'(5);
    localparam logic [POS_W-1:0] POS_HDR_LEN    = POS_W'(6);
    localparam logic [POS_W-1:0] POS_HDR_PAD    = POS_W'(7);
    localparam logic [POS_W-1:0] POS_AXES       = POS_W'(8);
    localparam logic [POS_W-1:0] POS_LAYOUT_VER = POS_W'(9);
    localparam logic [POS_W-1:0] POS_RSV0       = POS_W'(10);
    localparam logic [POS_W-1:0] POS_RSV1       = POS_W'(11);
    localparam logic [POS_W-1:0] POS_PERIOD     = POS_W'(12);
    localparam logic [POS_W-1:0] POS_COUNT      = POS_W'(16);
    localparam logic [POS_W-1:0] POS_MODEL      = POS_W'(20);
    localparam logic [POS_W-1:0] POS_PAY_LEN    = POS_W'(24);
    localparam logic [POS_W-1:0] POS_PAY_CRC    = POS_W'(28);
    localparam logic [POS_W-1:0] POS_RSV_TAIL   = POS_W'(32);
    localparam logic [POS_W-1:0] POS_HDR_CRC    = POS_W'(36);
    localparam logic [POS_W-1:0] POS_END        = POS_W'(40);

    // Expected byte values
    localparam logic [7:0] MAGIC [4] = '{8'h41, 8'h36, 8'h54, 8'h52};
    localparam logic [7:0] VERSION_LO_BYTE = 8'h01;
    localparam logic [7:0] LAYOUT_VER_BYTE = 8'h01;
    localparam logic [7:0] HDR_LEN_BYTE    = 8'(HEADER_BYTES);
    localparam logic [7:0] AXES_BYTE       = 8'(AXES);

    // Field checks
    localparam logic [31:0] PERIOD_10MS      = 32'd10000;
    localparam logic [31:0] PERIOD_20MS      = 32'd20000;
    localparam logic [31:0] PERIOD_40MS      = 32'd40000;
    localparam logic [31:0] MIN_SAMPLES      = 32'd2;
    localparam logic [31:0] BYTES_PER_SAMPLE = 32'(AXES * 2);
    localparam logic [31:0] MAX_SAMPLES_RST  = 32'd4096;

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPECTED_MODEL_ID = 1'b0,
        REG_MAX_SAMPLES       = 1'b1
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_BAD_FORMAT   = 3'd1,
        STATUS_BAD_VERSION  = 3'd2,
        STATUS_BAD_CRC      = 3'd3,
        STATUS_COUNT_RANGE  = 3'd4,
        STATUS_WRONG_MODEL  = 3'd5
    } status_t;

    // Fold one byte into the running CRC, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] s;
        s = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            s = s[0] ? ((s >> 1) ^ CRC_POLY) : (s >> 1);
        end
        return s;
    endfunction

    // Replace one byte lane of a little-endian field
    function automatic logic [31:0] put_lane(input logic [31:0] field, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] f;
        f = field;
        case (lane)
            2'd0: f[7:0]   = b;
            2'd1: f[15:8]  = b;
            2'd2: f[23:16] = b;
            default: f[31:24] = b;
        endcase
        return f;
    endfunction

endpackage

@@ hdl/track_header_validator.sv @@
// Motion-track header validator: byte-serial CRC, field capture and status check.
//
// Takes one header byte per clock cycle on the s_ channel and returns one result on
// the m_ channel per complete header, presented the cycle after its last byte is
// accepted. A byte with s_start_of_header set restarts the header; a partial header
// is dropped without a result. The CRC of a byte is folded combinationally, and the
// whole status decision is made in the cycle the last byte arrives, so a new byte is
// taken every cycle. The only stall is the last byte of a header arriving while the
// previous result is still held in the output register. The user must write the two
// configuration registers (expected model id, largest sample count) only while no
// header is in progress; the block does not enforce this. cfg_ready is always high.
module track_header_validator (
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [thv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,

    // header bytes
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_header_byte,
    input  logic                          s_start_of_header,

    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [31:0]                   m_sample_period,
    output logic [31:0]                   m_sample_count,
    output logic [31:0]                   m_track_model,
    output logic [31:0]                   m_data_crc
);

    // configuration registers
    logic [31:0] expected_model_reg;
    logic [31:0] max_samples_reg;

    // header state
    logic [thv_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] hdr_crc_reg, hdr_crc_next;
    logic [31:0] period_reg, period_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] model_reg, model_next;
    logic [31:0] pay_len_reg, pay_len_next;
    logic [31:0] pay_crc_reg, pay_crc_next;
    logic        magic_bad_reg, magic_bad_next;
    logic        version_bad_reg, version_bad_next;
    logic        layout_bad_reg, layout_bad_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    thv_pkg::status_t    status_reg, status_next;
    logic [31:0]         out_period_reg, out_period_next;
    logic [31:0]         out_count_reg, out_count_next;
    logic [31:0]         out_model_reg, out_model_next;
    logic [31:0]         out_pay_crc_reg, out_pay_crc_next;

    logic                      s_fire;
    logic                      is_last;
    logic                      out_load;
    logic [thv_pkg::POS_W-1:0] p;
    logic [31:0]               crc_final;
    logic [31:0]               expected_len;
    logic                      period_ok;
    logic                      early_fail;

    // effective position of the incoming byte
    assign p       = s_start_of_header ? '0 : pos_reg;
    assign is_last = (p == thv_pkg::LAST_POS);

    // take bytes unless a finishing byte would overrun a held result
    assign s_ready   = m_ready || !m_valid_reg || !is_last;
    assign s_fire    = s_valid && s_ready;
    assign out_load  = s_fire && is_last;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_model_reg <= '0;
            max_samples_reg    <= thv_pkg::MAX_SAMPLES_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (thv_pkg::cfg_reg_t'(cfg_index))
                thv_pkg::REG_EXPECTED_MODEL_ID: expected_model_reg <= cfg_data;
                thv_pkg::REG_MAX_SAMPLES:       max_samples_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // fold the byte into CRC, flags and fields
    always_comb begin
        crc_next         = crc_reg;
        magic_bad_next   = magic_bad_reg;
        version_bad_next = version_bad_reg;
        layout_bad_next  = layout_bad_reg;
        hdr_crc_next     = hdr_crc_reg;
        period_next      = period_reg;
        count_next       = count_reg;
        model_next       = model_reg;
        pay_len_next     = pay_len_reg;
        pay_crc_next     = pay_crc_reg;

        // restart on byte zero
        if (p == '0) begin
            crc_next         = thv_pkg::CRC_INIT;
            magic_bad_next   = 1'b0;
            version_bad_next = 1'b0;
            layout_bad_next  = 1'b0;
        end

        if (p < thv_pkg::POS_HDR_CRC) begin
            crc_next = thv_pkg::crc_byte(crc_next, s_header_byte);
        end

        if (p < thv_pkg::POS_VERSION_LO) begin
            if (s_header_byte != thv_pkg::MAGIC[p[1:0]]) magic_bad_next = 1'b1;
        end else if (p == thv_pkg::POS_VERSION_LO) begin
            if (s_header_byte != thv_pkg::VERSION_LO_BYTE) version_bad_next = 1'b1;
        end else if (p == thv_pkg::POS_VERSION_HI) begin
            if (s_header_byte != 8'd0) version_bad_next = 1'b1;
        end else if (p == thv_pkg::POS_HDR_LEN) begin
            if (s_header_byte != thv_pkg::HDR_LEN_BYTE) layout_bad_next = 1'b1;
        end else if (p == thv_pkg::POS_AXES) begin
            if (s_header_byte != thv_pkg::AXES_BYTE) layout_bad_next = 1'b1;
        end else if (p == thv_pkg::POS_LAYOUT_VER) begin
            if (s_header_byte != thv_pkg::LAYOUT_VER_BYTE) layout_bad_next = 1'b1;
        end else if (p == thv_pkg::POS_HDR_PAD || p == thv_pkg::POS_RSV0 ||
                     p == thv_pkg::POS_RSV1 ||
                     (p >= thv_pkg::POS_RSV_TAIL && p < thv_pkg::POS_HDR_CRC)) begin
            if (s_header_byte != 8'd0) layout_bad_next = 1'b1;
        end else if (p >= thv_pkg::POS_PERIOD && p < thv_pkg::POS_COUNT) begin
            period_next = thv_pkg::put_lane(period_reg, p[1:0], s_header_byte);
        end else if (p >= thv_pkg::POS_COUNT && p < thv_pkg::POS_MODEL) begin
            count_next = thv_pkg::put_lane(count_reg, p[1:0], s_header_byte);
        end else if (p >= thv_pkg::POS_MODEL && p < thv_pkg::POS_PAY_LEN) begin
            model_next = thv_pkg::put_lane(model_reg, p[1:0], s_header_byte);
        end else if (p >= thv_pkg::POS_PAY_LEN && p < thv_pkg::POS_PAY_CRC) begin
            pay_len_next = thv_pkg::put_lane(pay_len_reg, p[1:0], s_header_byte);
        end else if (p >= thv_pkg::POS_PAY_CRC && p < thv_pkg::POS_RSV_TAIL) begin
            pay_crc_next = thv_pkg::put_lane(pay_crc_reg, p[1:0], s_header_byte);
        end else if (p >= thv_pkg::POS_HDR_CRC && p < thv_pkg::POS_END) begin
            hdr_crc_next = thv_pkg::put_lane(hdr_crc_reg, p[1:0], s_header_byte);
        end

        // advance or wrap the position
        pos_next = is_last ? '0 : p + 1'b1;
    end

    // decide the status from the header as it stands after this byte
    assign crc_final    = ~crc_next;
    assign expected_len = count_next * thv_pkg::BYTES_PER_SAMPLE;
    assign period_ok    = (period_next == thv_pkg::PERIOD_10MS) ||
                          (period_next == thv_pkg::PERIOD_20MS) ||
                          (period_next == thv_pkg::PERIOD_40MS);
    assign early_fail   = magic_bad_next || version_bad_next ||
                          (hdr_crc_next != crc_final) || layout_bad_next;

    always_comb begin
        if (magic_bad_next) begin
            status_next = thv_pkg::STATUS_BAD_FORMAT;
        end else if (version_bad_next) begin
            status_next = thv_pkg::STATUS_BAD_VERSION;
        end else if (hdr_crc_next != crc_final) begin
            status_next = thv_pkg::STATUS_BAD_CRC;
        end else if (layout_bad_next) begin
            status_next = thv_pkg::STATUS_BAD_FORMAT;
        end else if (count_next < thv_pkg::MIN_SAMPLES || count_next > max_samples_reg) begin
            status_next = thv_pkg::STATUS_COUNT_RANGE;
        end else if (!period_ok || pay_len_next != expected_len) begin
            status_next = thv_pkg::STATUS_BAD_FORMAT;
        end else if (model_next != expected_model_reg) begin
            status_next = thv_pkg::STATUS_WRONG_MODEL;
        end else begin
            status_next = thv_pkg::STATUS_OK;
        end

        // zero the fields on an early failure
        out_period_next  = early_fail ? '0 : period_next;
        out_count_next   = early_fail ? '0 : count_next;
        out_model_next   = early_fail ? '0 : model_next;
        out_pay_crc_next = early_fail ? '0 : pay_crc_next;

        // hold a result until it is taken
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // header state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            crc_reg         <= thv_pkg::CRC_INIT;
            magic_bad_reg   <= 1'b0;
            version_bad_reg <= 1'b0;
            layout_bad_reg  <= 1'b0;
            hdr_crc_reg     <= '0;
            period_reg      <= '0;
            count_reg       <= '0;
            model_reg       <= '0;
            pay_len_reg     <= '0;
            pay_crc_reg     <= '0;
        end else if (s_fire) begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            magic_bad_reg   <= magic_bad_next;
            version_bad_reg <= version_bad_next;
            layout_bad_reg  <= layout_bad_next;
            hdr_crc_reg     <= hdr_crc_next;
            period_reg      <= period_next;
            count_reg       <= count_next;
            model_reg       <= model_next;
            pay_len_reg     <= pay_len_next;
            pay_crc_reg     <= pay_crc_next;
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg      <= status_next;
            out_period_reg  <= out_period_next;
            out_count_reg   <= out_count_next;
            out_model_reg   <= out_model_next;
            out_pay_crc_reg <= out_pay_crc_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_sample_period = out_period_reg;
    assign m_sample_count  = out_count_reg;
    assign m_track_model   = out_model_reg;
    assign m_data_crc      = out_pay_crc_reg;

    // the position never leaves the header
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < thv_pkg::POS_W'(thv_pkg::HEADER_BYTES))
        else $error("byte position out of header range");

    // a finishing byte always yields a result next cycle
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("last header byte produced no result");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_valid_reg) |-> m_ready)
        else $error("result overwritten before it was taken");

    // a start byte leaves the position at one
    a_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_start_of_header) |=> pos_reg == thv_pkg::POS_W'(1))
        else $error("start of header did not restart the position");

    // version and CRC failures carry zero fields
    a_early_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == thv_pkg::STATUS_BAD_VERSION ||
                     m_status == thv_pkg::STATUS_BAD_CRC)) |->
        (m_sample_period == '0 && m_sample_count == '0 && m_track_model == '0 &&
         m_data_crc == '0))
        else $error("early failure result carries nonzero fields");

endmodule
